// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/tdf_pkg.sv =====
`default_nettype none

package tdf_pkg;

  localparam int KEY_W         = 64;
  localparam int TIME_W        = 32;
  localparam int WIN_W         = 16;
  localparam int DEPTH_DEFAULT = 16;
  localparam int KEY_BITS_DEFAULT = 64;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WRITE
  } tdf_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] telegram_out;
    logic             is_duplicate;
    logic             evicted_live;
  } tdf_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdf_if.sv =====
`default_nettype none

interface tdf_in_if;
  import tdf_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  telegram_key;
  logic [TIME_W-1:0] arrival_ms;

  modport source (output valid, telegram_key, arrival_ms, input ready);
  modport sink   (input valid, telegram_key, arrival_ms, output ready);
endinterface

interface tdf_out_if;
  import tdf_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] telegram_out;
  logic             is_duplicate;
  logic             evicted_live;

  modport source (output valid, telegram_out, is_duplicate, evicted_live, input ready);
  modport sink   (input valid, telegram_out, is_duplicate, evicted_live, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/timed_duplicate_filter_top.sv =====
`default_nettype none

// Channel       Dir  Word
// telegram_in   in   telegram_key[63:0], arrival_ms[31:0]
// result_out    out  telegram_out[63:0], is_duplicate, evicted_live
// cfg_we/wdata  in   window_ms[15:0], written when cfg_we is high
//
// A word is taken only in idle; expired entries are then dropped from the oldest end,
// the remaining entries scanned for a live match, and the result offered for output.
// The single read port of the entry memory visits one entry at a time, a read state then a check state.
// A finished result sits in the output register while the next word is taken.
// Reset clears state, pointers, count and output valid, not the entries; window_ms returns to 1000.
module timed_duplicate_filter_top #(
  parameter int TABLE_DEPTH = tdf_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS    = tdf_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  tdf_in_if.sink                         telegram_in,
  tdf_out_if.source                      result_out,
  input  wire logic                      cfg_we,
  input  wire logic [tdf_pkg::WIN_W-1:0] cfg_wdata
);
  import tdf_pkg::*;

  `include "assert_macros.svh"

  logic [WIN_W-1:0] window;
  logic             res_valid;
  logic             res_ready;
  tdf_result_t      res;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  tdf_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .window      (window),
    .telegram_in (telegram_in),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !result_out.valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result_out.telegram_out <= res.telegram_out;
      result_out.is_duplicate <= res.is_duplicate;
      result_out.evicted_live <= res.evicted_live;
    end
  end

  `ASSERT_NEXT(a_result_loaded, clk, rst, res_valid && res_ready,
               result_out.valid, "result not presented")

endmodule

`default_nettype wire

// ===== hw/rtl/tdf_engine.sv =====
`default_nettype none

module tdf_engine #(
  parameter int TABLE_DEPTH = tdf_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS    = tdf_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [tdf_pkg::WIN_W-1:0] window,
  tdf_in_if.sink                         telegram_in,
  output      logic                      res_valid,
  input  wire logic                      res_ready,
  output      tdf_pkg::tdf_result_t      res
);
  import tdf_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

  // ring storage, contents undefined until written
  logic [KEY_BITS-1:0] mem_key  [TABLE_DEPTH];
  logic [TIME_W-1:0]   mem_time [TABLE_DEPTH];

  tdf_state_t          state, state_next;
  logic [IDX_W-1:0]    oldest, oldest_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    scan, scan_next;
  logic                dup, dup_next;
  logic [KEY_BITS-1:0] key_q;
  logic [TIME_W-1:0]   now_q;

  logic [IDX_W-1:0]    rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [TIME_W-1:0]   rd_time;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [TIME_W-1:0]   age;
  logic                live;
  logic                full;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(TABLE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(TABLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign age  = now_q - rd_time;
  assign live = age < {{(TIME_W-WIN_W){1'b0}}, window};
  assign full = (count == FULL);

  assign telegram_in.ready = (state == ST_IDLE);

  assign res_valid        = (state == ST_WRITE);
  assign res.telegram_out = KEY_W'(key_q);
  assign res.is_duplicate = dup;
  assign res.evicted_live = !dup && full;

  always_ff @(posedge clk) begin
    rd_key  <= mem_key[rd_addr];
    rd_time <= mem_time[rd_addr];
    if (wr_en) begin
      mem_key[wr_addr]  <= key_q;
      mem_time[wr_addr] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      oldest <= '0;
      count  <= '0;
      scan   <= '0;
      dup    <= 1'b0;
    end else begin
      state  <= state_next;
      oldest <= oldest_next;
      count  <= count_next;
      scan   <= scan_next;
      dup    <= dup_next;
    end
  end

  always_ff @(posedge clk) begin
    if (telegram_in.valid && telegram_in.ready) begin
      key_q <= telegram_in.telegram_key[KEY_BITS-1:0];
      now_q <= telegram_in.arrival_ms;
    end
  end

  always_comb begin
    state_next  = state;
    oldest_next = oldest;
    count_next  = count;
    scan_next   = scan;
    dup_next    = dup;
    rd_addr     = oldest;
    wr_en       = 1'b0;
    wr_addr     = slot_of(oldest, count[IDX_W-1:0]);
    unique case (state)
      ST_IDLE: begin
        if (telegram_in.valid) begin
          dup_next   = 1'b0;
          state_next = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        state_next = (count == '0) ? ST_WRITE : ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        if (!live) begin
          oldest_next = slot_of(oldest, IDX_W'(1));
          count_next  = count - CNT_W'(1);
          state_next  = ST_EXP_RD;
        end else begin
          scan_next  = '0;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        rd_addr    = slot_of(oldest, scan[IDX_W-1:0]);
        state_next = (scan == count) ? ST_WRITE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        scan_next = scan + CNT_W'(1);
        // out-of-order stamps: a later entry may be stale, skip it
        if (live && rd_key == key_q) begin
          dup_next   = 1'b1;
          state_next = ST_WRITE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_WRITE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
          if (!dup) begin
            wr_en = 1'b1;
            if (full) begin
              wr_addr     = oldest;
              oldest_next = slot_of(oldest, IDX_W'(1));
            end else begin
              count_next = count + CNT_W'(1);
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= FULL, "live count above depth")
  `ASSERT_NEXT(a_store_nonempty, clk, rst, res_valid && res_ready && !dup,
               count != '0, "stored word left ring empty")
  `ASSERT_NEXT(a_full_stays, clk, rst, res_valid && res_ready && res.evicted_live,
               count == FULL, "eviction changed live count")
  `ASSERT_NEXT(a_hold_result, clk, rst, res_valid && !res_ready,
               res_valid && $stable(res), "pending result changed")

endmodule

`default_nettype wire
